### src/grfc_pkg.sv
// Shared constants, codes and transaction types for the grid region four-coloring block.
`default_nettype none
package grfc_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int DEF_MAX_REGIONS = 26;
	localparam int DEF_MAX_COLS    = 64;
	localparam int DEF_MAX_ROWS    = 64;

	// Fixed field widths
	localparam int LABEL_W    = 5;
	localparam int COUNT_W    = 5;
	localparam int DIM_W      = 7;
	localparam int COLOR_W    = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int NUM_COLORS = 4;

	// Link queue between front and back; depth is a power of two so pointers wrap
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REGION_COUNT = 2'd0,
		CFG_GRID_ROWS    = 2'd1,
		CFG_GRID_COLS    = 2'd2
	} cfg_idx_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_COLORED     = 2'd0,
		ST_NO_SOLUTION = 2'd1,
		ST_NO_REGIONS  = 2'd2
	} status_t;

	// One adjacency mark between two regions
	typedef struct packed {
		logic               valid;
		logic [LABEL_W-1:0] a;
		logic [LABEL_W-1:0] b;
	} link_t;

	// Per-cell transaction from the front to the back
	typedef struct packed {
		logic               first;
		logic               last;
		logic [COUNT_W-1:0] count;
		link_t              left;
		link_t              up;
	} cell_event_t;

endpackage
`default_nettype wire

### src/grfc_queue.sv
// Short FIFO carrying cell transactions from the front to the back.
`default_nettype none
module grfc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  grfc_pkg::cell_event_t push_data,
	input  wire                   pop,
	output logic                  not_empty,
	output logic                  almost_full,
	output grfc_pkg::cell_event_t head
);

	grfc_pkg::cell_event_t        slot_q [grfc_pkg::QDEPTH];
	logic [grfc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [grfc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [grfc_pkg::QPTR_W:0]    count_q;

	assign not_empty   = (count_q != '0);
	// room kept for one cell in flight plus one being accepted
	assign almost_full = (count_q >= (grfc_pkg::QPTR_W + 1)'(grfc_pkg::QDEPTH - 2));
	assign head        = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + grfc_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + grfc_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (grfc_pkg::QPTR_W + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (grfc_pkg::QPTR_W + 1)'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

### src/grfc_front.sv
// Cell front end: raster position, previous-row line store and neighbor link extraction.
`default_nettype none
module grfc_front #(
	parameter int MAX_REGIONS = grfc_pkg::DEF_MAX_REGIONS,
	parameter int MAX_COLS    = grfc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS    = grfc_pkg::DEF_MAX_ROWS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire  [grfc_pkg::LABEL_W-1:0]   cell_label,
	input  wire  [grfc_pkg::COUNT_W-1:0]   region_count,
	input  wire  [grfc_pkg::DIM_W-1:0]     grid_rows,
	input  wire  [grfc_pkg::DIM_W-1:0]     grid_cols,
	input  wire                            hold,
	input  wire                            done,
	output logic                           busy,
	output logic                           ev_valid,
	output grfc_pkg::cell_event_t          ev
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int MW1   = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W = ((MW1 > grfc_pkg::DIM_W) ? MW1 : grfc_pkg::DIM_W) + 1;
	localparam int CNT_X = grfc_pkg::COUNT_W + 1;

	logic [COL_W-1:0]             cell_col_q;
	logic [ROW_W-1:0]             cell_row_q;
	logic [grfc_pkg::LABEL_W-1:0] left_label_q;
	logic                         run_pend_q;
	logic [grfc_pkg::LABEL_W-1:0] line_store [MAX_COLS];

	logic                           v_s1;
	logic [grfc_pkg::LABEL_W-1:0]   lab_s1;
	logic [grfc_pkg::LABEL_W-1:0]   left_s1;
	logic [grfc_pkg::LABEL_W-1:0]   up_s1;
	logic                           has_left_s1;
	logic                           has_up_s1;
	logic                           first_s1;
	logic                           last_s1;
	logic [grfc_pkg::COUNT_W-1:0]   n_s1;

	logic                         accept;
	logic [CMP_W-1:0]             cols_eff;
	logic [CMP_W-1:0]             rows_eff;
	logic                         col_end;
	logic                         row_end;
	logic [grfc_pkg::COUNT_W-1:0] n_eff;

	function automatic logic link_ok(input logic [grfc_pkg::LABEL_W-1:0] a,
			input logic [grfc_pkg::LABEL_W-1:0] b, input logic [grfc_pkg::COUNT_W-1:0] n);
		return (a != b) && (a < n) && (b < n);
	endfunction

	assign busy   = run_pend_q | hold;
	assign accept = start & ~busy;

	// Saturate the grid size and region count
	always_comb begin
		if (grid_cols == '0)
			cols_eff = CMP_W'(1);
		else if (CMP_W'(grid_cols) > CMP_W'(MAX_COLS))
			cols_eff = CMP_W'(MAX_COLS);
		else
			cols_eff = CMP_W'(grid_cols);
		if (grid_rows == '0)
			rows_eff = CMP_W'(1);
		else if (CMP_W'(grid_rows) > CMP_W'(MAX_ROWS))
			rows_eff = CMP_W'(MAX_ROWS);
		else
			rows_eff = CMP_W'(grid_rows);
		if (CNT_X'(region_count) > CNT_X'(MAX_REGIONS))
			n_eff = grfc_pkg::COUNT_W'(MAX_REGIONS);
		else
			n_eff = region_count;
	end

	assign col_end = (CMP_W'(cell_col_q) + CMP_W'(1)) >= cols_eff;
	assign row_end = (CMP_W'(cell_row_q) + CMP_W'(1)) >= rows_eff;

	// Position, left label, pending run and stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_col_q   <= '0;
			cell_row_q   <= '0;
			left_label_q <= '0;
			run_pend_q   <= 1'b0;
			v_s1         <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				left_label_q <= cell_label;
				if (col_end) begin
					cell_col_q <= '0;
					if (row_end)
						cell_row_q <= '0;
					else
						cell_row_q <= cell_row_q + ROW_W'(1);
				end else begin
					cell_col_q <= cell_col_q + COL_W'(1);
				end
			end
			if (accept && col_end && row_end)
				run_pend_q <= 1'b1;
			else if (done)
				run_pend_q <= 1'b0;
		end
	end

	// Line store: read the label above, then overwrite with the current one
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1                  <= line_store[cell_col_q];
			line_store[cell_col_q] <= cell_label;
		end
	end

	// Stage-1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			lab_s1      <= cell_label;
			left_s1     <= left_label_q;
			has_left_s1 <= (cell_col_q != '0);
			has_up_s1   <= (cell_row_q != '0);
			first_s1    <= (cell_col_q == '0) && (cell_row_q == '0);
			last_s1     <= col_end && row_end;
			n_s1        <= n_eff;
		end
	end

	// Build the transaction for the back
	assign ev_valid      = v_s1;
	assign ev.first      = first_s1;
	assign ev.last       = last_s1;
	assign ev.count      = n_s1;
	assign ev.left.valid = has_left_s1 && link_ok(lab_s1, left_s1, n_s1);
	assign ev.left.a     = lab_s1;
	assign ev.left.b     = left_s1;
	assign ev.up.valid   = has_up_s1 && link_ok(lab_s1, up_s1, n_s1);
	assign ev.up.a       = lab_s1;
	assign ev.up.b       = up_s1;

endmodule
`default_nettype wire

### src/grfc_back.sv
// Back end: adjacency matrix, backtracking color search and result sequencing.
`default_nettype none
module grfc_back #(
	parameter int MAX_REGIONS = grfc_pkg::DEF_MAX_REGIONS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            ev_valid,
	input  grfc_pkg::cell_event_t          ev,
	output logic                           pop,
	output logic                           done,
	output logic                           result_valid,
	output logic [grfc_pkg::LABEL_W-1:0]   region,
	output logic [grfc_pkg::COLOR_W-1:0]   color,
	output logic [grfc_pkg::STATUS_W-1:0]  status,
	output logic                           last_result
);

	localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

	typedef enum logic [3:0] {
		S_LOAD   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_EMIT   = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [grfc_pkg::COUNT_W-1:0]   idx_q;
	logic [grfc_pkg::COUNT_W-1:0]   n_q;
	grfc_pkg::status_t              status_q;
	logic [MAX_REGIONS-1:0]         adj_q   [MAX_REGIONS];
	logic [MAX_REGIONS-1:0]         adj_d   [MAX_REGIONS];
	logic [grfc_pkg::COLOR_W-1:0]   color_q [MAX_REGIONS];

	logic                           result_valid_q;
	logic [grfc_pkg::LABEL_W-1:0]   region_q;
	logic [grfc_pkg::COLOR_W-1:0]   color_out_q;
	grfc_pkg::status_t              status_out_q;
	logic                           last_q;

	logic [MAX_REGIONS-1:0]         adj_row;
	logic [grfc_pkg::COLOR_W-1:0]   cur_color;
	logic [grfc_pkg::NUM_COLORS-1:0] used;
	logic                           found;
	logic [grfc_pkg::COLOR_W-1:0]   pick;
	logic                           emit_last;

	assign pop       = (state_q == S_LOAD) && ev_valid;
	assign emit_last = (idx_q + grfc_pkg::COUNT_W'(1)) == n_q;
	assign done      = ((state_q == S_EMIT) && emit_last) || (state_q == S_REPORT);

	// Next adjacency: clear on frame start, then mark both links symmetrically
	always_comb begin
		for (int r = 0; r < MAX_REGIONS; r++) begin
			adj_d[r] = ev.first ? '0 : adj_q[r];
			if (ev.left.valid && ev.left.a[RW-1:0] == RW'(r))
				adj_d[r][ev.left.b[RW-1:0]] = 1'b1;
			if (ev.left.valid && ev.left.b[RW-1:0] == RW'(r))
				adj_d[r][ev.left.a[RW-1:0]] = 1'b1;
			if (ev.up.valid && ev.up.a[RW-1:0] == RW'(r))
				adj_d[r][ev.up.b[RW-1:0]] = 1'b1;
			if (ev.up.valid && ev.up.b[RW-1:0] == RW'(r))
				adj_d[r][ev.up.a[RW-1:0]] = 1'b1;
		end
	end

	// Colors held by already-colored neighbors of the current region
	always_comb begin
		adj_row   = adj_q[idx_q[RW-1:0]];
		cur_color = color_q[idx_q[RW-1:0]];
		used      = '0;
		for (int j = 0; j < MAX_REGIONS; j++) begin
			if (adj_row[j] && (grfc_pkg::COUNT_W'(j) < n_q) && (grfc_pkg::COUNT_W'(j) != idx_q)) begin
				for (int k = 0; k < grfc_pkg::NUM_COLORS; k++) begin
					if (color_q[j] == grfc_pkg::COLOR_W'(k + 1))
						used[k] = 1'b1;
				end
			end
		end
	end

	// Lowest free color above the current one
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int k = 0; k < grfc_pkg::NUM_COLORS; k++) begin
			if (!found && (grfc_pkg::COLOR_W'(k + 1) > cur_color) && !used[k]) begin
				found = 1'b1;
				pick  = grfc_pkg::COLOR_W'(k + 1);
			end
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == S_EMIT) || (state_q == S_REPORT);
			unique case (state_q)
				S_LOAD: begin
					if (ev_valid && ev.last) begin
						idx_q <= '0;
						if (ev.count == '0)
							state_q <= S_REPORT;
						else if (ev.count <= grfc_pkg::COUNT_W'(2))
							state_q <= S_EMIT;
						else
							state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (idx_q >= n_q) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else if (found) begin
						idx_q <= idx_q + grfc_pkg::COUNT_W'(1);
					end else if (idx_q == '0) begin
						state_q <= S_REPORT;
					end else begin
						idx_q <= idx_q - grfc_pkg::COUNT_W'(1);
					end
				end
				S_EMIT: begin
					if (emit_last)
						state_q <= S_LOAD;
					else
						idx_q <= idx_q + grfc_pkg::COUNT_W'(1);
				end
				S_REPORT: begin
					state_q <= S_LOAD;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Adjacency, colors and run parameters
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int r = 0; r < MAX_REGIONS; r++)
				adj_q[r] <= adj_d[r];
			if (ev.last) begin
				n_q      <= ev.count;
				status_q <= grfc_pkg::ST_NO_REGIONS;
				for (int r = 0; r < MAX_REGIONS; r++)
					color_q[r] <= '0;
			end
		end
		if ((state_q == S_SEARCH) && (idx_q < n_q)) begin
			color_q[idx_q[RW-1:0]] <= found ? pick : '0;
			if (!found && idx_q == '0)
				status_q <= grfc_pkg::ST_NO_SOLUTION;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			region_q     <= idx_q;
			color_out_q  <= (n_q <= grfc_pkg::COUNT_W'(2))
				? (grfc_pkg::COLOR_W'(idx_q) + grfc_pkg::COLOR_W'(1))
				: color_q[idx_q[RW-1:0]];
			status_out_q <= grfc_pkg::ST_COLORED;
			last_q       <= emit_last;
		end else if (state_q == S_REPORT) begin
			region_q     <= '0;
			color_out_q  <= '0;
			status_out_q <= status_q;
			last_q       <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign region       = region_q;
	assign color        = color_out_q;
	assign status       = status_out_q;
	assign last_result  = last_q;

endmodule
`default_nettype wire

### src/grid_region_four_coloring.sv
// Top level of the grid region four-coloring block: configuration registers and wiring.
//
// Usage:
//  - Configure region_count, grid_rows and grid_cols through cfg_we/cfg_index/cfg_data
//    while the block is idle; each write takes effect at the clock edge.
//  - Present grid cells in raster order on cell_label with start high; a cell is
//    accepted at an edge where start is high and busy is low. One cell per cycle while busy stays low.
//  - Each cell passes a front stage (line store read into a register, link extraction
//    on the way into a four-entry queue) and is merged into the adjacency matrix when
//    the back end pops it from the queue.
//  - After the last cell busy stays high; it drops in the cycle the final result appears.
//    For a count above two the search then runs one step per cycle: each step colors
//    or uncolors one region, so its length depends on the map. Results follow at one
//    per cycle: one per region, or a single no-solution or no-regions result, the last
//    one flagged by last_result.
//  - Each result is held on the output ports for exactly one cycle with result_valid
//    high; the receiver cannot stall.
//  - Reset returns position to the grid origin and the sequencer to loading. The line
//    store needs no clearing; the adjacency matrix is cleared by the first cell of a grid.
`default_nettype none
module grid_region_four_coloring #(
	parameter int MAX_REGIONS = grfc_pkg::DEF_MAX_REGIONS,
	parameter int MAX_COLS    = grfc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS    = grfc_pkg::DEF_MAX_ROWS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [grfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [grfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                              start,
	input  wire  [grfc_pkg::LABEL_W-1:0]     cell_label,
	output logic                             busy,
	output logic                             result_valid,
	output logic [grfc_pkg::LABEL_W-1:0]     region,
	output logic [grfc_pkg::COLOR_W-1:0]     color,
	output logic [grfc_pkg::STATUS_W-1:0]    status,
	output logic                             last_result
);

	logic [grfc_pkg::COUNT_W-1:0] region_count_q;
	logic [grfc_pkg::DIM_W-1:0]   grid_rows_q;
	logic [grfc_pkg::DIM_W-1:0]   grid_cols_q;

	logic                  front_valid;
	grfc_pkg::cell_event_t front_ev;
	logic                  q_not_empty;
	logic                  q_almost_full;
	grfc_pkg::cell_event_t q_head;
	logic                  back_pop;
	logic                  back_done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
			grid_rows_q    <= grfc_pkg::DIM_W'(1);
			grid_cols_q    <= grfc_pkg::DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				grfc_pkg::CFG_REGION_COUNT: region_count_q <= cfg_data[grfc_pkg::COUNT_W-1:0];
				grfc_pkg::CFG_GRID_ROWS:    grid_rows_q    <= cfg_data;
				grfc_pkg::CFG_GRID_COLS:    grid_cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	grfc_front #(
		.MAX_REGIONS (MAX_REGIONS),
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cell_label   (cell_label),
		.region_count (region_count_q),
		.grid_rows    (grid_rows_q),
		.grid_cols    (grid_cols_q),
		.hold         (q_almost_full),
		.done         (back_done),
		.busy         (busy),
		.ev_valid     (front_valid),
		.ev           (front_ev)
	);

	grfc_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (front_valid),
		.push_data   (front_ev),
		.pop         (back_pop),
		.not_empty   (q_not_empty),
		.almost_full (q_almost_full),
		.head        (q_head)
	);

	grfc_back #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (q_not_empty),
		.ev           (q_head),
		.pop          (back_pop),
		.done         (back_done),
		.result_valid (result_valid),
		.region       (region),
		.color        (color),
		.status       (status),
		.last_result  (last_result)
	);

endmodule
`default_nettype wire
